// ===== src/erow_pkg.sv =====
// ----------------------------------------------------------------------------
// erow_pkg
// Shared types and constants of the overwrite-oldest event capture ring.
// ----------------------------------------------------------------------------
`default_nettype none

package erow_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 256;
  localparam int FILL_W     = 9;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_OVERWROTE = 3'd1,
    ST_FILTERED  = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [63:0] stamp;
    logic        drop;
    logic        injected;
    logic [9:0]  code;
    logic [4:0]  ev_type;
    logic [31:0] value;
  } row_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  addr;
    logic [63:0]       seq;
    status_t           status;
    logic              drop;
    logic [FILL_W-1:0] fill;
    logic [63:0]       drops;
  } req_t;

endpackage

`default_nettype wire

// ===== src/erow_mem.sv =====
// ----------------------------------------------------------------------------
// erow_mem
// Single-port entry store of the ring, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module erow_mem
  import erow_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic             rd_en,
  input  wire logic [PTR_W-1:0] addr,
  input  wire row_t             wr_data,
  output row_t                  rd_data_r
);

  row_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/erow_ctrl.sv =====
// ----------------------------------------------------------------------------
// erow_ctrl
// Ring pointers, fill count, sequence and drop counters, filter register.
// ----------------------------------------------------------------------------
`default_nettype none

module erow_ctrl
  import erow_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  input  wire logic accept,
  input  wire logic command,
  input  wire logic injected,
  output req_t      req
);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [63:0]      seq_r, seq_nxt;
  logic [63:0]      drops_r, drops_nxt;
  logic             incl_r;
  logic             full;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_inc;

  assign full     = (count_r == CNT_W'(RING_DEPTH));
  assign tail_sum = (PTR_W+1)'(head_r) + (PTR_W+1)'(count_r);
  assign tail     = (tail_sum >= (PTR_W+1)'(RING_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W+1)'(RING_DEPTH)) : tail_sum[PTR_W-1:0];
  assign head_inc = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    seq_nxt    = seq_r;
    drops_nxt  = drops_r;
    req.wr_en  = 1'b0;
    req.rd_en  = 1'b0;
    req.addr   = head_r;
    req.drop   = 1'b0;
    req.status = ST_QUEUED;
    if (command == CMD_PUSH) begin
      if (injected && !incl_r) begin
        req.status = ST_FILTERED;
      end else begin
        seq_nxt   = seq_r + 64'd1;
        req.wr_en = accept;
        if (full) begin
          req.addr   = head_r;
          req.drop   = 1'b1;
          req.status = ST_OVERWROTE;
          head_nxt   = head_inc;
          drops_nxt  = drops_r + 64'd1;
        end else begin
          req.addr   = tail;
          count_nxt  = count_r + 1'b1;
        end
      end
    end else begin
      if (count_r == '0) begin
        req.status = ST_EMPTY;
      end else begin
        req.rd_en  = accept;
        req.status = ST_POPPED;
        head_nxt   = head_inc;
        count_nxt  = count_r - 1'b1;
      end
    end
    req.seq   = seq_nxt;
    req.fill  = FILL_W'(count_nxt);
    req.drops = drops_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      seq_r   <= '0;
      drops_r <= '0;
      incl_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        incl_r <= cfg_wr_data;
      end
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
        seq_r   <= seq_nxt;
        drops_r <= drops_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/event_ring_overwrite_oldest_top.sv =====
// ----------------------------------------------------------------------------
// event_ring_overwrite_oldest_top
// Event capture ring of 256 entries that overwrites the oldest entry when
// full.
//
// Input channel in_*: in_tuser selects push (0) or pop (1); in_tdata carries
// the event. Every transfer yields exactly one result on out_*: out_tuser is
// the status, out_tdata the popped entry, fill level and drop total.
// The store is read at the transfer edge while the pending stage captures the
// status; the output register loads from the pending stage once it is free.
// Throughput: one transfer per cycle while out_tready stays high; the single
// stage between the store read and the output register sets that figure.
// When the receiver stalls, the output register holds its result, one more
// transfer is taken into the read stage, and in_tready then drops until the
// output register is taken.
// Reset (rst_n low, synchronous) empties the ring, clears the sequence and
// drop counters and the include-injected register; stored entries are not
// cleared and need no clearing pass.
// cfg_wr_en writes cfg_wr_data into include-injected; write only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module event_ring_overwrite_oldest_top
  import erow_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // injected[0], ev_type[5:1], ev_code[15:6], ev_value[47:16], stamp_ns[111:48]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_seq[63:0], out_stamp[127:64], out_type[132:128], out_code[142:133],
  // out_value[174:143], out_injected[175], dropped_before[176],
  // fill_level[185:177], total_drops[249:186], zero[255:250]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[2:0]
  output logic [2:0]                 out_tuser
);

  req_t              req;
  row_t              wr_row;
  row_t              rd_row;
  logic              in_xfer;
  logic              pend_move;
  logic              pend_r;
  status_t           pend_status_r;
  logic              pend_drop_r;
  logic [FILL_W-1:0] pend_fill_r;
  logic [63:0]       pend_drops_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]        out_user_r;
  row_t              res_row;

  assign pend_move = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || pend_move;
  assign in_xfer   = in_tvalid && in_tready;

  erow_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_xfer),
    .command     (in_tuser),
    .injected    (in_tdata[0]),
    .req         (req)
  );

  always_comb begin
    wr_row.seq      = req.seq;
    wr_row.stamp    = in_tdata[111:48];
    wr_row.drop     = req.drop;
    wr_row.injected = in_tdata[0];
    wr_row.code     = in_tdata[15:6];
    wr_row.ev_type  = in_tdata[5:1];
    wr_row.value    = in_tdata[47:16];
  end

  erow_mem u_mem (
    .clk       (clk),
    .wr_en     (req.wr_en),
    .rd_en     (req.rd_en),
    .addr      (req.addr),
    .wr_data   (wr_row),
    .rd_data_r (rd_row)
  );

  always_comb begin
    res_row = '0;
    if (pend_status_r == ST_POPPED) begin
      res_row = rd_row;
    end
    out_data_nxt          = '0;
    out_data_nxt[63:0]    = res_row.seq;
    out_data_nxt[127:64]  = res_row.stamp;
    out_data_nxt[132:128] = res_row.ev_type;
    out_data_nxt[142:133] = res_row.code;
    out_data_nxt[174:143] = res_row.value;
    out_data_nxt[175]     = res_row.injected;
    out_data_nxt[176]     = (pend_status_r == ST_POPPED) ? res_row.drop : pend_drop_r;
    out_data_nxt[185:177] = pend_fill_r;
    out_data_nxt[249:186] = pend_drops_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (pend_move) begin
        pend_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_status_r <= req.status;
      pend_drop_r   <= req.drop;
      pend_fill_r   <= req.fill;
      pend_drops_r  <= req.drops;
    end
    if (pend_move) begin
      out_data_r <= out_data_nxt;
      out_user_r <= pend_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !pend_move |=> pend_r)
    else $error("pending transfer lost");

  a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> pend_r)
    else $error("accepted transfer not pending");

  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && req.drop |-> req.status == ST_OVERWROTE && req.wr_en)
    else $error("overwrite without matching status");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr_en && req.rd_en))
    else $error("store read and write in one cycle");

endmodule

`default_nettype wire

// ===== dv/event_ring_overwrite_oldest_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_ring_overwrite_oldest_top_test
// Self-checking bench for the overwrite-oldest event capture ring. A queue of
// push and pop commands feeds a stream driver; each accepted command runs
// through a local ring predictor, and a monitor compares every result
// transfer field by field. Phases vary the include-injected setting, the
// idle pattern of both sides and the share of pushes in each run.
// ----------------------------------------------------------------------------

module event_ring_overwrite_oldest_top_test
  import erow_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 172;

  typedef struct packed {
    logic        cmd;
    logic        inj;
    logic [4:0]  etype;
    logic [9:0]  code;
    logic [31:0] value;
    logic [63:0] stamp;
  } event_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [63:0] stamp;
    logic [4:0]  etype;
    logic [9:0]  code;
    logic [31:0] value;
    logic        inj;
    logic        drop;
  } slot_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] seq;
    logic [63:0] stamp;
    logic [4:0]  etype;
    logic [9:0]  code;
    logic [31:0] value;
    logic        inj;
    logic        drop;
    logic [8:0]  fill;
    logic [63:0] drops;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;

  event_ring_overwrite_oldest_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring predictor state
  slot_t       ring [RING_DEPTH];
  int          ring_head = 0;
  int          ring_fill = 0;
  logic [63:0] seq_count = '0;
  logic [63:0] overwrite_total = '0;
  logic        incl_inj = 1'b0;

  event_t      pending_events [$];
  outcome_t    expected_outcomes [$];
  logic        in_fire = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  int          n_queued = 0, n_overwrote = 0, n_filtered = 0, n_popped = 0, n_empty = 0;
  event_t      accepted_event;
  outcome_t    want;

  function automatic outcome_t predict_outcome(event_t e);
    outcome_t r;
    int       slot;
    logic     dropped;
    r = '0;
    dropped = 1'b0;
    if (e.cmd == CMD_PUSH) begin
      if (e.inj && !incl_inj) begin
        r.status = ST_FILTERED;
        n_filtered++;
      end else begin
        if (ring_fill >= RING_DEPTH) begin
          overwrite_total = overwrite_total + 64'd1;
          dropped = 1'b1;
          slot = ring_head;
          ring_head = (ring_head + 1) % RING_DEPTH;
        end else begin
          slot = (ring_head + ring_fill) % RING_DEPTH;
          ring_fill++;
        end
        seq_count = seq_count + 64'd1;
        ring[slot].seq   = seq_count;
        ring[slot].stamp = e.stamp;
        ring[slot].etype = e.etype;
        ring[slot].code  = e.code;
        ring[slot].value = e.value;
        ring[slot].inj   = e.inj;
        ring[slot].drop  = dropped;
        if (dropped) begin
          r.status = ST_OVERWROTE;
          n_overwrote++;
        end else begin
          r.status = ST_QUEUED;
          n_queued++;
        end
        r.drop = dropped;
      end
    end else begin
      if (ring_fill == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        slot = ring_head;
        r.status = ST_POPPED;
        r.seq    = ring[slot].seq;
        r.stamp  = ring[slot].stamp;
        r.etype  = ring[slot].etype;
        r.code   = ring[slot].code;
        r.value  = ring[slot].value;
        r.inj    = ring[slot].inj;
        r.drop   = ring[slot].drop;
        ring_head = (ring_head + 1) % RING_DEPTH;
        ring_fill--;
        n_popped++;
      end
    end
    r.fill  = ring_fill[8:0];
    r.drops = overwrite_total;
    return r;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_event(event_t e);
    return {e.stamp, e.value, e.code, e.etype, e.inj};
  endfunction

  function automatic event_t make_push(logic inj, logic [4:0] etype, logic [9:0] code,
                                       logic [31:0] value, logic [63:0] stamp);
    event_t e;
    e.cmd   = CMD_PUSH;
    e.inj   = inj;
    e.etype = etype;
    e.code  = code;
    e.value = value;
    e.stamp = stamp;
    return e;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_stamp();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return {64{1'b1}};
      2: return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic event_t random_event(int push_pct);
    event_t e;
    e = make_push($urandom_range(0, 3) == 0, 5'($urandom_range(0, 31)),
                  10'($urandom_range(0, 1023)), pick_value(), pick_stamp());
    if ($urandom_range(0, 99) >= push_pct) e.cmd = CMD_POP;
    return e;
  endfunction

  function automatic event_t make_pop();
    event_t e;
    e = random_event(0);
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    errors++;
    $display("mismatch %s at cycle %0d: got %0h, expected %0h", what, cycles, got, exp_val);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_include(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    incl_inj = v;
  endtask

  task automatic run_random(input int n, input int push_pct, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    @(negedge clk);
    repeat (n) pending_events.push_back(random_event(push_pct));
    wait_drained();
  endtask

  // Driver: present the queue head, hold it until the transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold
    end else if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_tvalid <= 1'b1;
      in_tuser  <= pending_events[0].cmd;
      in_tdata  <= pack_event(pending_events[0]);
    end else begin
      in_tvalid <= 1'b0;
    end
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      accepted_event = pending_events.pop_front();
      expected_outcomes.push_back(predict_outcome(accepted_event));
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tuser), 64'h0);
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status",         64'(out_tuser),          64'(want.status));
        check_field("out_seq",        out_tdata[63:0],         want.seq);
        check_field("out_stamp",      out_tdata[127:64],       want.stamp);
        check_field("out_type",       64'(out_tdata[132:128]), 64'(want.etype));
        check_field("out_code",       64'(out_tdata[142:133]), 64'(want.code));
        check_field("out_value",      64'(out_tdata[174:143]), 64'(want.value));
        check_field("out_injected",   64'(out_tdata[175]),     64'(want.inj));
        check_field("dropped_before", 64'(out_tdata[176]),     64'(want.drop));
        check_field("fill_level",     64'(out_tdata[185:177]), 64'(want.fill));
        check_field("total_drops",    out_tdata[249:186],      want.drops);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL event_ring_overwrite_oldest_top");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 61;
    write_include(1'b0);
    @(negedge clk);
    pending_events.push_back(make_pop());
    pending_events.push_back(make_push(1'b0, 5'd0, 10'd0, 32'h0, 64'h0));
    pending_events.push_back(make_push(1'b0, 5'd31, 10'd1023, 32'h7fff_ffff, {64{1'b1}}));
    pending_events.push_back(make_push(1'b0, 5'd1, 10'd512, 32'h8000_0000,
                                       64'h8000_0000_0000_0000));
    pending_events.push_back(make_push(1'b0, 5'd16, 10'd1, 32'hffff_ffff, 64'h1));
    pending_events.push_back(make_push(1'b1, 5'd31, 10'd1023, 32'hffff_ffff, {64{1'b1}}));
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    wait_drained();

    write_include(1'b1);
    @(negedge clk);
    pending_events.push_back(make_push(1'b1, 5'd31, 10'd1023, 32'h8000_0000, {64{1'b1}}));
    pending_events.push_back(make_push(1'b0, 5'd0, 10'd0, 32'h7fff_ffff, 64'h0));
    pending_events.push_back(make_push(1'b1, 5'd10, 10'd341, 32'h5555_aaaa,
                                       64'h5555_aaaa_5555_aaaa));
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    pending_events.push_back(make_pop());
    wait_drained();

    write_include(1'b1);
    run_random(PHASE_ITEMS, 90, 24, 61);
    write_include(1'b0);
    run_random(PHASE_ITEMS, 85, 24, 61);
    write_include(1'b0);
    run_random(PHASE_ITEMS, 35, 61, 24);
    write_include(1'b1);
    run_random(PHASE_ITEMS, 92, 61, 24);
    write_include(1'b1);
    run_random(PHASE_ITEMS, 25, 0, 0);
    write_include(1'b0);
    run_random(PHASE_ITEMS, 10, 0, 0);

    repeat (10) @(posedge clk);
    $display("covered %0d queued, %0d overwriting, %0d filtered, %0d popped, %0d empty pops",
             n_queued, n_overwrote, n_filtered, n_popped, n_empty);
    $display("final drop total %0d, %0d mismatches", overwrite_total, errors);
    if (errors == 0) begin
      $display("PASS event_ring_overwrite_oldest_top");
    end else begin
      $display("FAIL event_ring_overwrite_oldest_top");
    end
    $finish;
  end

endmodule
